// ----- rtl/ddpc_pkg.sv -----
// Shared constants, register codes and pipeline types of the position controller.
package ddpc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 32;
	localparam int GEOM_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

	// square root radicand and distance widths
	localparam int RAD_W  = 2 * SQRT_STEPS;
	localparam int DIST_W = SQRT_STEPS + 2;
	localparam logic [63:0] RAD_LIM = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - RAD_W);

	// PID accumulator: widest product plus two guard bits
	localparam int ACC_W = (SQRT_STEPS + 21 > 50) ? SQRT_STEPS + 21 : 50;
	localparam int PID_SH = 20;
	localparam int TRN_W  = ACC_W - PID_SH;

	localparam int PI_Q12   = 12868;
	localparam int PI_2_Q12 = 6434;
	localparam logic signed [32:0] PI_Q28 = 33'sd843314857;
	localparam int PRESCALE_SH = 28;

	// atan(2^-i) in units of 2^-28 rad
	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
		32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
		32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
		32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64, 32'd32
	};

	typedef enum logic [2:0] {
		REG_CONTROL_MODE,
		REG_DIRECTION_MODE,
		REG_SPEED_LIMIT,
		REG_ANGLE_TOL,
		REG_DIST_TOL,
		REG_ANG_GAINS,
		REG_LIN_GAINS
	} reg_idx_t;

	typedef enum logic [2:0] {
		CTRL_ANGLE,
		CTRL_DISTANCE,
		CTRL_POSITION,
		CTRL_ANGLE_THEN_POS,
		CTRL_ANGLE_AND_POS
	} ctrl_mode_t;

	typedef enum logic [1:0] {
		DIR_FORWARD,
		DIR_BACKWARD,
		DIR_EITHER
	} dir_mode_t;

	typedef struct packed {
		logic [2:0]  control_mode;
		logic [1:0]  direction_mode;
		logic [14:0] speed_limit;
		logic [14:0] angle_tolerance;
		logic [30:0] distance_tolerance;
		logic [47:0] angular_gains;
		logic [47:0] linear_gains;
	} cfg_t;

	// per item values that ride alongside the CORDIC and root stages
	typedef struct packed {
		logic signed [14:0] rh;
		logic signed [15:0] hdiff;
		logic               nz;
		logic               sh;
		logic signed [31:0] a_int;
		logic signed [31:0] a_rate;
		logic signed [31:0] d_int;
		logic signed [31:0] d_rate;
	} ctx_t;

	typedef struct packed {
		logic               valid;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [32:0] z;
		logic [RAD_W-1:0]   v;
		logic [RAD_W-1:0]   res;
		ctx_t               ctx;
	} geom_t;

endpackage

// ----- rtl/ddpc_chan_if.sv -----
// Handshake channel interfaces: pose items, wheel powers and register writes.
interface ddpc_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [14:0] robot_heading;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [14:0] target_heading;
	logic signed [31:0] angle_integral;
	logic signed [31:0] angle_rate;
	logic signed [31:0] distance_integral;
	logic signed [31:0] distance_rate;

	modport source (
		output valid, robot_x, robot_y, robot_heading, target_x, target_y, target_heading,
		output angle_integral, angle_rate, distance_integral, distance_rate,
		input  ready
	);
	modport sink (
		input  valid, robot_x, robot_y, robot_heading, target_x, target_y, target_heading,
		input  angle_integral, angle_rate, distance_integral, distance_rate,
		output ready
	);
endinterface

interface ddpc_power_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] left_power;
	logic signed [16:0] right_power;

	modport source (output valid, left_power, right_power, input ready);
	modport sink (input valid, left_power, right_power, output ready);
endinterface

interface ddpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ddpc_front.sv -----
// Front stages: pose differences, CORDIC pre-rotation, squares and radicand.
module ddpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	ddpc_pose_if.sink        pose,
	output ddpc_pkg::geom_t  g_o
);

	logic signed [32:0] dx, dy, cy;
	logic [31:0]        adx, ady;
	logic [30:0]        axh, ayh;
	logic               sh;
	logic signed [32:0] z0;
	ddpc_pkg::ctx_t     ctx;

	logic               valid_s1;
	logic [30:0]        axh_s1, ayh_s1;
	logic [31:0]        cx_s1;
	logic signed [32:0] cy_s1, z_s1;
	ddpc_pkg::ctx_t     ctx_s1;

	logic               valid_s2;
	logic [61:0]        sqx_s2, sqy_s2;
	logic [31:0]        cx_s2;
	logic signed [32:0] cy_s2, z_s2;
	ddpc_pkg::ctx_t     ctx_s2;

	logic [63:0]        rad_sum, rad_sat;

	assign pose.ready = en;

	always_comb begin
		dx  = 33'(pose.target_x) - 33'(pose.robot_x);
		dy  = 33'(pose.target_y) - 33'(pose.robot_y);
		adx = dx[32] ? 32'(-dx) : dx[31:0];
		ady = dy[32] ? 32'(-dy) : dy[31:0];
		cy  = dx[32] ? -dy : dy;
		if (dx[32]) begin
			z0 = dy[32] ? -ddpc_pkg::PI_Q28 : ddpc_pkg::PI_Q28;
		end else begin
			z0 = '0;
		end
		// offsets of 2^31 or more are halved so the squares stay in range
		sh  = adx[31] | ady[31];
		axh = sh ? adx[31:1] : adx[30:0];
		ayh = sh ? ady[31:1] : ady[30:0];
		ctx.rh     = pose.robot_heading;
		ctx.hdiff  = 16'(pose.target_heading) - 16'(pose.robot_heading);
		ctx.nz     = (dx != '0) || (dy != '0);
		ctx.sh     = sh;
		ctx.a_int  = pose.angle_integral;
		ctx.a_rate = pose.angle_rate;
		ctx.d_int  = pose.distance_integral;
		ctx.d_rate = pose.distance_rate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pose.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axh_s1 <= axh;
			ayh_s1 <= ayh;
			cx_s1  <= adx;
			cy_s1  <= cy;
			z_s1   <= z0;
			ctx_s1 <= ctx;
			sqx_s2 <= axh_s1 * axh_s1;
			sqy_s2 <= ayh_s1 * ayh_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			z_s2   <= z_s1;
			ctx_s2 <= ctx_s1;
		end
	end

	always_comb begin
		rad_sum = 64'(sqx_s2) + 64'(sqy_s2);
		rad_sat = (rad_sum > ddpc_pkg::RAD_LIM) ? ddpc_pkg::RAD_LIM : rad_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_o <= '0;
		end else if (en) begin
			g_o.valid <= valid_s2;
			g_o.x     <= $signed({4'b0, cx_s2, 28'b0});
			g_o.y     <= $signed({{3{cy_s2[32]}}, cy_s2, 28'b0});
			g_o.z     <= z_s2;
			g_o.v     <= ddpc_pkg::RAD_W'(rad_sat);
			g_o.res   <= '0;
			g_o.ctx   <= ctx_s2;
		end
	end

endmodule

// ----- rtl/ddpc_geom.sv -----
// Restoring sqrt step per stage; CORDIC atan2 step in early stages.
module ddpc_geom (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ddpc_pkg::geom_t  g_i,
	output ddpc_pkg::geom_t  g_o
);

	ddpc_pkg::geom_t geo_s [ddpc_pkg::GEOM_STAGES+1];

	assign geo_s[0] = g_i;
	assign g_o      = geo_s[ddpc_pkg::GEOM_STAGES];

	for (genvar k = 0; k < ddpc_pkg::GEOM_STAGES; k++) begin : g_stage
		logic signed [63:0]         x_n, y_n;
		logic signed [32:0]         z_n;
		logic [ddpc_pkg::RAD_W-1:0] v_n, res_n;

		if (k < ddpc_pkg::CORDIC_STEPS) begin : g_cordic
			logic signed [63:0] xs, ys;
			logic signed [32:0] at;
			always_comb begin
				xs = $signed(geo_s[k].x) >>> k;
				ys = $signed(geo_s[k].y) >>> k;
				at = $signed({1'b0, ddpc_pkg::ATAN_TAB[k]});
				if (!geo_s[k].y[63]) begin
					x_n = geo_s[k].x + ys;
					y_n = geo_s[k].y - xs;
					z_n = geo_s[k].z + at;
				end else begin
					x_n = geo_s[k].x - ys;
					y_n = geo_s[k].y + xs;
					z_n = geo_s[k].z - at;
				end
			end
		end else begin : g_cordic_idle
			assign x_n = geo_s[k].x;
			assign y_n = geo_s[k].y;
			assign z_n = geo_s[k].z;
		end

		if (k < ddpc_pkg::SQRT_STEPS) begin : g_sqrt
			localparam logic [ddpc_pkg::RAD_W-1:0] SqBit =
				{{(ddpc_pkg::RAD_W-1){1'b0}}, 1'b1} << (ddpc_pkg::RAD_W - 2 - 2 * k);
			logic [ddpc_pkg::RAD_W-1:0] trial;
			always_comb begin
				trial = geo_s[k].res + SqBit;
				if (geo_s[k].v >= trial) begin
					v_n   = geo_s[k].v - trial;
					res_n = (geo_s[k].res >> 1) + SqBit;
				end else begin
					v_n   = geo_s[k].v;
					res_n = geo_s[k].res >> 1;
				end
			end
		end else begin : g_sqrt_idle
			assign v_n   = geo_s[k].v;
			assign res_n = geo_s[k].res;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				geo_s[k+1] <= '0;
			end else if (en) begin
				geo_s[k+1].valid <= geo_s[k].valid;
				geo_s[k+1].x     <= x_n;
				geo_s[k+1].y     <= y_n;
				geo_s[k+1].z     <= z_n;
				geo_s[k+1].v     <= v_n;
				geo_s[k+1].res   <= res_n;
				geo_s[k+1].ctx   <= geo_s[k].ctx;
			end
		end
	end

endmodule

// ----- rtl/ddpc_law.sv -----
// Control law: bearing wrap, direction fold, PID products, clamp and wheel mix.
module ddpc_law (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ddpc_pkg::cfg_t     cfg,
	input  ddpc_pkg::geom_t    g_i,
	output logic               valid_o,
	output logic signed [16:0] left_o,
	output logic signed [16:0] right_o
);

	typedef struct packed {
		logic use_a;
		logic use_l;
		logic dir_neg;
		logic stop;
	} law_flags_t;

	typedef struct packed {
		logic signed [31:0] a_int;
		logic signed [31:0] a_rate;
		logic signed [31:0] d_int;
		logic signed [31:0] d_rate;
	} pid_in_t;

	localparam int DW = ddpc_pkg::DIST_W;
	localparam int AW = ddpc_pkg::ACC_W;
	localparam int TW = ddpc_pkg::TRN_W;

	// stage 1: rounded bearing, wrap, distance
	logic signed [32:0] zsum;
	logic signed [16:0] zr;
	logic signed [17:0] alpha0, alpha_w;
	logic [DW-1:0]      dist_c;

	logic               valid_s1;
	logic signed [17:0] alpha_s1;
	logic [DW-1:0]      dist_s1;
	logic signed [15:0] hdiff_s1;
	pid_in_t            pin_s1;

	always_comb begin
		zsum = g_i.z + 33'sd32768;
		zr   = 17'(zsum >>> 16);
		alpha0 = g_i.ctx.nz ? (18'(zr) - 18'(g_i.ctx.rh)) : '0;
		if (alpha0 < -18'sd12868) begin
			alpha_w = alpha0 + 18'(2 * ddpc_pkg::PI_Q12);
		end else if (alpha0 > 18'(ddpc_pkg::PI_Q12)) begin
			alpha_w = alpha0 - 18'(2 * ddpc_pkg::PI_Q12);
		end else begin
			alpha_w = alpha0;
		end
		dist_c = DW'(g_i.res[ddpc_pkg::SQRT_STEPS:0]) << g_i.ctx.sh;
	end

	// stage 2: direction fold, mode decisions
	logic signed [17:0] alpha_f, err_a, absa, absh;
	logic               dneg;
	law_flags_t         flg;

	logic               valid_s2;
	logic signed [17:0] err_s2;
	logic [DW-1:0]      dist_s2;
	law_flags_t         flg_s2;
	pid_in_t            pin_s2;

	always_comb begin
		alpha_f = alpha_s1;
		dneg    = 1'b0;
		unique case (ddpc_pkg::dir_mode_t'(cfg.direction_mode))
			ddpc_pkg::DIR_BACKWARD: begin
				dneg    = 1'b1;
				alpha_f = alpha_s1 + 18'(ddpc_pkg::PI_Q12);
				if (alpha_f > 18'(ddpc_pkg::PI_Q12)) begin
					alpha_f = alpha_f - 18'(2 * ddpc_pkg::PI_Q12);
				end
			end
			ddpc_pkg::DIR_EITHER: begin
				if (alpha_s1 > 18'(ddpc_pkg::PI_2_Q12)) begin
					alpha_f = alpha_s1 - 18'(ddpc_pkg::PI_Q12);
					dneg    = 1'b1;
				end else if (alpha_s1 < -18'sd6434) begin
					alpha_f = alpha_s1 + 18'(ddpc_pkg::PI_Q12);
					dneg    = 1'b1;
				end
			end
			default: begin
			end
		endcase
		absa = alpha_f[17] ? -alpha_f : alpha_f;
		absh = hdiff_s1[15] ? -18'(hdiff_s1) : 18'(hdiff_s1);
		err_a = alpha_f;
		flg.use_a   = 1'b0;
		flg.use_l   = 1'b0;
		flg.dir_neg = dneg;
		unique case (cfg.control_mode)
			ddpc_pkg::CTRL_ANGLE: begin
				err_a     = 18'(hdiff_s1);
				flg.use_a = 1'b1;
			end
			ddpc_pkg::CTRL_ANGLE_THEN_POS: begin
				if (absa > 18'(cfg.angle_tolerance)) begin
					flg.use_a = 1'b1;
				end else if (dist_s1 > DW'(cfg.distance_tolerance)) begin
					flg.use_l = 1'b1;
				end
			end
			ddpc_pkg::CTRL_ANGLE_AND_POS: begin
				flg.use_a = 1'b1;
				flg.use_l = 1'b1;
			end
			default: begin
			end
		endcase
		flg.stop = (absh < 18'(cfg.angle_tolerance)) &&
			(dist_s1 < DW'(cfg.distance_tolerance));
	end

	// stage 3: six gain products
	logic signed [15:0] ap, ai, ad, lp, li, ld;
	logic signed [DW:0] dist_sg;

	logic               valid_s3;
	logic signed [33:0] pap_s3;
	logic signed [47:0] pai_s3, pad_s3, pli_s3, pld_s3;
	logic signed [DW+16:0] plp_s3;
	law_flags_t         flg_s3;

	assign ap = $signed(cfg.angular_gains[15:0]);
	assign ai = $signed(cfg.angular_gains[31:16]);
	assign ad = $signed(cfg.angular_gains[47:32]);
	assign lp = $signed(cfg.linear_gains[15:0]);
	assign li = $signed(cfg.linear_gains[31:16]);
	assign ld = $signed(cfg.linear_gains[47:32]);
	assign dist_sg = $signed({1'b0, dist_s2});

	// stage 4: sums
	logic               valid_s4;
	logic signed [AW-1:0] suma_s4, suml_s4;
	law_flags_t         flg_s4;

	// stage 5: truncate toward zero, clamp
	logic signed [AW-1:0] rnda, rndl;
	logic signed [TW-1:0] trna, trnl, lim_t;
	logic signed [15:0]   lim16, ta, tl;

	logic               valid_s5;
	logic signed [15:0] ta_s5, tl_s5;
	law_flags_t         flg_s5;

	always_comb begin
		rnda  = suma_s4 + (suma_s4[AW-1] ? AW'((1 << ddpc_pkg::PID_SH) - 1) : '0);
		rndl  = suml_s4 + (suml_s4[AW-1] ? AW'((1 << ddpc_pkg::PID_SH) - 1) : '0);
		trna  = TW'(rnda >>> ddpc_pkg::PID_SH);
		trnl  = TW'(rndl >>> ddpc_pkg::PID_SH);
		lim16 = $signed({1'b0, cfg.speed_limit});
		lim_t = TW'(lim16);
		if (trna > lim_t) begin
			ta = lim16;
		end else if (trna < -lim_t) begin
			ta = -lim16;
		end else begin
			ta = 16'(trna);
		end
		if (trnl > lim_t) begin
			tl = lim16;
		end else if (trnl < -lim_t) begin
			tl = -lim16;
		end else begin
			tl = 16'(trnl);
		end
	end

	// stage 6: wheel mix and stop band, held as the output register
	logic signed [16:0] la, ll;

	always_comb begin
		la = flg_s5.use_a ? 17'(ta_s5) : '0;
		if (!flg_s5.use_l) begin
			ll = '0;
		end else if (flg_s5.dir_neg) begin
			ll = -17'(tl_s5);
		end else begin
			ll = 17'(tl_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (en) begin
			valid_s1 <= g_i.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_o  <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s1 <= alpha_w;
			dist_s1  <= dist_c;
			hdiff_s1 <= g_i.ctx.hdiff;
			pin_s1   <= '{g_i.ctx.a_int, g_i.ctx.a_rate, g_i.ctx.d_int, g_i.ctx.d_rate};

			err_s2  <= err_a;
			dist_s2 <= dist_s1;
			flg_s2  <= flg;
			pin_s2  <= pin_s1;

			pap_s3 <= ap * err_s2;
			pai_s3 <= ai * pin_s2.a_int;
			pad_s3 <= ad * pin_s2.a_rate;
			plp_s3 <= lp * dist_sg;
			pli_s3 <= li * pin_s2.d_int;
			pld_s3 <= ld * pin_s2.d_rate;
			flg_s3 <= flg_s2;

			suma_s4 <= AW'(pap_s3) + AW'(pai_s3) + AW'(pad_s3);
			suml_s4 <= AW'(plp_s3) + AW'(pli_s3) + AW'(pld_s3);
			flg_s4  <= flg_s3;

			ta_s5  <= ta;
			tl_s5  <= tl;
			flg_s5 <= flg_s4;

			left_o  <= flg_s5.stop ? '0 : (ll - la);
			right_o <= flg_s5.stop ? '0 : (ll + la);
		end
	end

endmodule

// ----- rtl/diff_drive_position_controller_unit.sv -----
// Pipeline: front, root/CORDIC and law stages lie between pose transfer and power result.
// Throughput: one pose per cycle; the whole pipeline advances together and holds while
//   a finished result waits for its transfer, so input ready follows result ready directly.
// Reset: arst_n clears every stage valid bit and all configuration registers to zero.
// Configuration writes are taken every cycle and must only come while the pipe is empty.
module diff_drive_position_controller_unit (
	input  logic          clk,
	input  logic          arst_n,
	ddpc_pose_if.sink     pose,
	ddpc_power_if.source  power,
	ddpc_cfg_if.sink      cfg
);

	ddpc_pkg::cfg_t  cfg_q;
	ddpc_pkg::geom_t front_g, geom_g;
	logic            en;
	logic            out_valid;
	logic signed [16:0] left_q, right_q;

	// global advance: move unless a result is parked and not taken
	assign en = !out_valid || power.ready;

	// register file, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ddpc_pkg::REG_CONTROL_MODE:   cfg_q.control_mode       <= cfg.data[2:0];
				ddpc_pkg::REG_DIRECTION_MODE: cfg_q.direction_mode     <= cfg.data[1:0];
				ddpc_pkg::REG_SPEED_LIMIT:    cfg_q.speed_limit        <= cfg.data[14:0];
				ddpc_pkg::REG_ANGLE_TOL:      cfg_q.angle_tolerance    <= cfg.data[14:0];
				ddpc_pkg::REG_DIST_TOL:       cfg_q.distance_tolerance <= cfg.data[30:0];
				ddpc_pkg::REG_ANG_GAINS:      cfg_q.angular_gains      <= cfg.data;
				ddpc_pkg::REG_LIN_GAINS:      cfg_q.linear_gains       <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// differences, squares and CORDIC pre-rotation
	ddpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.pose   (pose),
		.g_o    (front_g)
	);

	// bearing and distance iterations side by side
	ddpc_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.g_i    (front_g),
		.g_o    (geom_g)
	);

	// PID, clamp and mix; last stage is the output register
	ddpc_law u_law (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.g_i     (geom_g),
		.valid_o (out_valid),
		.left_o  (left_q),
		.right_o (right_q)
	);

	assign power.valid       = out_valid;
	assign power.left_power  = left_q;
	assign power.right_power = right_q;

	// each wheel is the sum of two clamped 16-bit terms
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		power.valid |-> (power.left_power <= 17'sd65534 && power.left_power >= -17'sd65534 &&
			power.right_power <= 17'sd65534 && power.right_power >= -17'sd65534))
		else $error("wheel power beyond two clamped terms");

	// a parked result must hold the input side
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		(power.valid && !power.ready) |-> !pose.ready)
		else $error("input accepted while output stalled");

endmodule

// ----- bench/tb_diff_drive_position_controller_unit.sv -----
// Self-checking bench for the differential drive position controller unit.
module tb_diff_drive_position_controller_unit;

	// one pose item as offered on the input channel
	typedef struct {
		logic signed [31:0] rx, ry, tx, ty;
		logic signed [14:0] rh, th;
		logic signed [31:0] a_int, a_rate, d_int, d_rate;
	} pose_item_t;

	typedef struct {
		logic signed [16:0] left, right;
	} wheel_pair_t;

	// queue of expected wheel powers, oldest first
	class wheel_power_board;
		wheel_pair_t pending[$];

		function void note(wheel_pair_t w);
			pending.push_back(w);
		endfunction

		// returns 0 with a message when the transfer is unexpected or wrong
		function bit check(logic signed [16:0] l, logic signed [16:0] r, output string msg);
			wheel_pair_t w;
			msg = "";
			if (pending.size() == 0) begin
				msg = $sformatf("unexpected power transfer L=%0d R=%0d", l, r);
				return 0;
			end
			w = pending.pop_front();
			if (l !== w.left)
				msg = $sformatf("left_power %0d, wanted %0d", l, w.left);
			if (r !== w.right)
				msg = {msg, $sformatf(" right_power %0d, wanted %0d", r, w.right)};
			return msg == "";
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int errors;
	bit calm;          // set for a stretch where neither side idles
	wheel_power_board board;

	ddpc_pose_if  pose();
	ddpc_power_if power();
	ddpc_cfg_if   cfg();

	diff_drive_position_controller_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pose  (pose),
		.power (power),
		.cfg   (cfg)
	);

	// shadow of the configuration registers
	logic [2:0]  sh_ctrl;
	logic [1:0]  sh_dir;
	logic [14:0] sh_speed;
	logic [14:0] sh_atol;
	logic [30:0] sh_dtol;
	logic [47:0] sh_again;
	logic [47:0] sh_lgain;

	initial clk = 0;
	always #4 clk = ~clk;

	// hard ceiling on run length
	initial begin
		#4000000;
		$display("tb_diff_drive_position_controller_unit NOT OK");
		$finish;
	end

	task automatic report(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// PID term: exact Q.20 sum, truncated toward zero, clamped to the speed limit
	function automatic longint pid_term(logic [47:0] g, longint err, longint integ,
			longint rate);
		longint p, ig, d, lim, t;
		p   = longint'($signed(g[15:0]));
		ig  = longint'($signed(g[31:16]));
		d   = longint'($signed(g[47:32]));
		lim = longint'(sh_speed);
		t   = (p * err + ig * integ + d * rate) / 64'sd1048576;
		if (t > lim) t = lim;
		if (t < -lim) t = -lim;
		return t;
	endfunction

	// expected wheel powers for one pose
	function automatic wheel_pair_t wheel_powers(pose_item_t p);
		longint dx, dy, hdiff, alpha, dist_v, left, right, t, absa, dir;
		longint x, y, z, xs, ys;
		longint unsigned ax, ay, v, res, bitv;
		bit sh;
		wheel_pair_t w;
		dx = longint'(p.tx) - longint'(p.rx);
		dy = longint'(p.ty) - longint'(p.ry);
		hdiff = longint'(p.th) - longint'(p.rh);
		alpha = 0;
		left = 0;
		right = 0;
		dir = 1;
		sh = 0;

		// bearing by CORDIC vectoring, half-plane folded first
		if (dx != 0 || dy != 0) begin
			x = dx;
			y = dy;
			z = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = (dy >= 0) ? longint'(ddpc_pkg::PI_Q28) : -longint'(ddpc_pkg::PI_Q28);
			end
			x = x <<< ddpc_pkg::PRESCALE_SH;
			y = y <<< ddpc_pkg::PRESCALE_SH;
			for (int i = 0; i < ddpc_pkg::CORDIC_STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += longint'(ddpc_pkg::ATAN_TAB[i]);
				end else begin
					x -= ys; y += xs; z -= longint'(ddpc_pkg::ATAN_TAB[i]);
				end
			end
			alpha = ((z + 32768) >>> 16) - longint'(p.rh);
		end
		if (alpha < -ddpc_pkg::PI_Q12)
			alpha += 2 * ddpc_pkg::PI_Q12;
		else if (alpha > ddpc_pkg::PI_Q12)
			alpha -= 2 * ddpc_pkg::PI_Q12;

		// distance: halve very large offsets, saturate radicand, bitwise root
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if ((ax >> 31) != 0 || (ay >> 31) != 0) begin
			ax >>= 1; ay >>= 1; sh = 1;
		end
		v = ax * ax + ay * ay;
		if (v > ddpc_pkg::RAD_LIM) v = ddpc_pkg::RAD_LIM;
		res = 0;
		bitv = 64'd1 << (2 * ddpc_pkg::SQRT_STEPS - 2);
		for (int i = 0; i < ddpc_pkg::SQRT_STEPS; i++) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		dist_v = longint'(res << sh);

		// direction folding; unused code 3 behaves as forward
		if (sh_dir == ddpc_pkg::DIR_BACKWARD) begin
			dir = -1;
			alpha += ddpc_pkg::PI_Q12;
			if (alpha > ddpc_pkg::PI_Q12) alpha -= 2 * ddpc_pkg::PI_Q12;
		end else if (sh_dir == ddpc_pkg::DIR_EITHER) begin
			if (alpha > ddpc_pkg::PI_2_Q12) begin
				alpha -= ddpc_pkg::PI_Q12; dir = -1;
			end else if (alpha < -ddpc_pkg::PI_2_Q12) begin
				alpha += ddpc_pkg::PI_Q12; dir = -1;
			end
		end

		case (sh_ctrl)
			ddpc_pkg::CTRL_ANGLE: begin
				t = pid_term(sh_again, hdiff, p.a_int, p.a_rate);
				left = -t; right = t;
			end
			ddpc_pkg::CTRL_ANGLE_THEN_POS: begin
				absa = alpha < 0 ? -alpha : alpha;
				if (absa > longint'(sh_atol)) begin
					t = pid_term(sh_again, alpha, p.a_int, p.a_rate);
					left = -t; right = t;
				end else if (dist_v > longint'(sh_dtol)) begin
					t = pid_term(sh_lgain, dist_v, p.d_int, p.d_rate);
					left = t * dir; right = t * dir;
				end
			end
			ddpc_pkg::CTRL_ANGLE_AND_POS: begin
				t = pid_term(sh_again, alpha, p.a_int, p.a_rate);
				left = -t; right = t;
				t = pid_term(sh_lgain, dist_v, p.d_int, p.d_rate);
				left += t * dir; right += t * dir;
			end
			default: ;   // distance, position and spare codes give no drive
		endcase

		// stop band applies in every mode
		absa = hdiff < 0 ? -hdiff : hdiff;
		if (absa < longint'(sh_atol) && dist_v < longint'(sh_dtol)) begin
			left = 0; right = 0;
		end
		w.left = left[16:0];
		w.right = right[16:0];
		return w;
	endfunction

	// register write, mirrored into the shadow copy on transfer
	task automatic write_reg(ddpc_pkg::reg_idx_t idx, logic [47:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			ddpc_pkg::REG_CONTROL_MODE:   sh_ctrl  = data[2:0];
			ddpc_pkg::REG_DIRECTION_MODE: sh_dir   = data[1:0];
			ddpc_pkg::REG_SPEED_LIMIT:    sh_speed = data[14:0];
			ddpc_pkg::REG_ANGLE_TOL:      sh_atol  = data[14:0];
			ddpc_pkg::REG_DIST_TOL:       sh_dtol  = data[30:0];
			ddpc_pkg::REG_ANG_GAINS:      sh_again = data;
			ddpc_pkg::REG_LIN_GAINS:      sh_lgain = data;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [2:0] cm, logic [1:0] dm, logic [14:0] sl,
			logic [14:0] at, logic [30:0] dt, logic [47:0] ag, logic [47:0] lg);
		write_reg(ddpc_pkg::REG_CONTROL_MODE, 48'(cm));
		write_reg(ddpc_pkg::REG_DIRECTION_MODE, 48'(dm));
		write_reg(ddpc_pkg::REG_SPEED_LIMIT, 48'(sl));
		write_reg(ddpc_pkg::REG_ANGLE_TOL, 48'(at));
		write_reg(ddpc_pkg::REG_DIST_TOL, 48'(dt));
		write_reg(ddpc_pkg::REG_ANG_GAINS, ag);
		write_reg(ddpc_pkg::REG_LIN_GAINS, lg);
		cfg.valid <= 1'b0;
	endtask

	// offer one pose; a random gap may come first
	task automatic send_pose(pose_item_t p);
		while (!calm && $urandom_range(99) < 17) begin
			pose.valid <= 1'b0;
			@(posedge clk);
		end
		pose.valid          <= 1'b1;
		pose.robot_x        <= p.rx;
		pose.robot_y        <= p.ry;
		pose.robot_heading  <= p.rh;
		pose.target_x       <= p.tx;
		pose.target_y       <= p.ty;
		pose.target_heading <= p.th;
		pose.angle_integral <= p.a_int;
		pose.angle_rate     <= p.a_rate;
		pose.distance_integral <= p.d_int;
		pose.distance_rate  <= p.d_rate;
		do @(posedge clk); while (!pose.ready);
		board.note(wheel_powers(p));
	endtask

	task automatic drain();
		pose.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic signed [14:0] rand_heading();
		// mostly within +/-pi, now and then anything the field holds
		if ($urandom_range(9) == 0)
			return 15'($urandom);
		return 15'($signed($urandom_range(2 * ddpc_pkg::PI_Q12)) - ddpc_pkg::PI_Q12);
	endfunction

	function automatic pose_item_t rand_pose();
		pose_item_t p;
		int span;
		span = $urandom_range(3);
		p.rx = $urandom;
		p.ry = $urandom;
		if (span == 3) begin
			p.tx = $urandom;
			p.ty = $urandom;
		end else begin
			// near target, so stop bands and small distances are reached
			p.tx = p.rx + ($signed($urandom) >>> (8 + 8 * span));
			p.ty = p.ry + ($signed($urandom) >>> (8 + 8 * span));
			if ($urandom_range(19) == 0) p.ty = p.ry;
			if ($urandom_range(19) == 0) p.tx = p.rx;
		end
		p.rh = rand_heading();
		p.th = ($urandom_range(3) == 0) ? p.rh + 15'($signed($urandom_range(60)) - 30)
			: rand_heading();
		p.a_int = $signed($urandom) >>> $urandom_range(31);
		p.a_rate = $signed($urandom) >>> $urandom_range(31);
		p.d_int = $signed($urandom) >>> $urandom_range(31);
		p.d_rate = $signed($urandom) >>> $urandom_range(31);
		return p;
	endfunction

	// result side: random back-pressure, check every transfer
	always @(posedge clk) begin
		string msg;
		if (arst_n && power.valid && power.ready)
			if (!board.check(power.left_power, power.right_power, msg))
				report(msg);
		power.ready <= calm || ($urandom_range(99) >= 17);
	end

	initial begin
		pose_item_t p;
		logic [2:0] cm;
		board = new();
		errors = 0;
		calm = 0;
		arst_n = 0;
		pose.valid = 0;
		pose.robot_x = 0; pose.robot_y = 0; pose.robot_heading = 0;
		pose.target_x = 0; pose.target_y = 0; pose.target_heading = 0;
		pose.angle_integral = 0; pose.angle_rate = 0;
		pose.distance_integral = 0; pose.distance_rate = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		sh_ctrl = 0; sh_dir = 0; sh_speed = 0; sh_atol = 0; sh_dtol = 0;
		sh_again = 0; sh_lgain = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: one pose at reset values, then extremes in combined mode
		p = '{default: 0};
		send_pose(p);
		drain();
		write_all(ddpc_pkg::CTRL_ANGLE_AND_POS, ddpc_pkg::DIR_FORWARD, 15'h7FFF, 0, 0,
			48'h7FFF_8000_0100, 48'h8000_7FFF_0080);
		// target on robot: bearing is not offset by heading
		p = '{rx: 100, ry: -5, tx: 100, ty: -5, rh: 12868, th: -12868, default: 0};
		send_pose(p);
		// widest offsets force the halved root
		p = '{rx: 32'sh8000_0000, ry: 32'sh7FFF_FFFF, tx: 32'sh7FFF_FFFF,
			ty: 32'sh8000_0000, rh: -12868, th: 12868, a_int: 32'sh7FFF_FFFF,
			a_rate: 32'sh8000_0000, d_int: 32'sh8000_0000, d_rate: 32'sh7FFF_FFFF};
		send_pose(p);
		p = '{rx: 0, ry: 0, tx: -4096, ty: 0, rh: 15'sh3FFF, th: 15'sh4000, default: 0};
		send_pose(p);
		// x difference zero, both signs of y
		p = '{rx: 7, ry: 0, tx: 7, ty: 4096, default: 0};
		send_pose(p);
		p = '{rx: 7, ry: 0, tx: 7, ty: -4096, default: 0};
		send_pose(p);
		p = '{rx: 0, ry: 0, tx: -4096, ty: -1, rh: 12868, default: 0};
		send_pose(p);
		drain();
		// stop band hit with maximal tolerances, then the extremes of direction codes
		for (int d = 0; d < 4; d++) begin
			cm = (d == 0) ? 3'(ddpc_pkg::CTRL_ANGLE_THEN_POS)
				: 3'(ddpc_pkg::CTRL_ANGLE_AND_POS);
			write_all(cm, 2'(d), 15'd20000, (d == 0) ? 15'h7FFF : 15'd300,
				(d == 0) ? 31'h7FFF_FFFF : 31'd4096, 48'($urandom) << 16 | 48'($urandom),
				48'($urandom) << 16 | 48'($urandom));
			for (int k = 0; k < 4; k++)
				send_pose(rand_pose());
			drain();
		end

		// random phases through every control mode and setting
		for (int ph = 0; ph < 19; ph++) begin
			cm = (ph == 17) ? 3'd7 : (ph == 18) ? 3'd5 : 3'(ph % 5);
			write_all(cm, 2'($urandom_range(3)),
				(ph % 6 == 0) ? 15'd0 : (ph % 6 == 1) ? 15'h7FFF : 15'($urandom),
				(ph % 4 == 0) ? 15'd0 : 15'($urandom_range(2000)),
				(ph % 4 == 1) ? 31'h7FFF_FFFF : 31'($urandom_range(1 << 20)),
				{16'($urandom), 16'($urandom), 16'($urandom)},
				{16'($urandom), 16'($urandom), 16'($urandom)});
			calm = (ph == 5);
			for (int k = 0; k < 100; k++)
				send_pose(rand_pose());
			drain();
		end
		calm = 0;

		if (errors == 0)
			$display("tb_diff_drive_position_controller_unit OK");
		else
			$display("tb_diff_drive_position_controller_unit NOT OK");
		$finish;
	end

endmodule
